>>> rtl/rrts_pkg.sv
// Package for the round-robin task scheduler: sizes, codes and the
// command and status structs between controller and datapath.
// No dependencies.
package rrts_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int IDLE_SLOT = 0;

	localparam int SLOT_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int SLEEP_W  = 29;
	localparam int TICKS_W  = 32;
	localparam int PARENT_W = 4;
	localparam int CODE_W   = 32;
	localparam int MS_W     = 32;

	localparam logic [SLOT_W-1:0] IDLE_IX   = SLOT_W'(IDLE_SLOT % NUM_SLOTS);
	localparam logic [SLOT_W-1:0] BOOT_IX   = SLOT_W'(1 % NUM_SLOTS);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

	localparam logic [CODE_W-1:0] KILL_CODE = CODE_W'(9);

	// Division by the tick length is a multiply by a rounded-up reciprocal
	// followed by a right shift of DIV_SHIFT bits.
	localparam int MS_PER_TICK = 10;
	localparam int DIV_SHIFT   = 35;
	localparam logic [63:0] DIV_MAGIC = ((64'd1 << DIV_SHIFT) / MS_PER_TICK) + 64'd1;

	typedef logic [SLOT_W-1:0] slot_ix_t;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_CREATE = 3'd1,
		OP_KILL   = 3'd2,
		OP_SLEEP  = 3'd3,
		OP_EXIT   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_UNUSED   = 3'd0,
		ST_READY    = 3'd1,
		ST_RUNNING  = 3'd2,
		ST_SLEEPING = 3'd3,
		ST_ZOMBIE   = 3'd4
	} slot_st_t;

	typedef enum logic [1:0] {
		RES_OK        = 2'd0,
		RES_UNUSED    = 2'd1,
		RES_PROTECTED = 2'd2,
		RES_FULL      = 2'd3
	} res_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic fin_cur;
		logic fin_next;
		logic create;
		logic kill;
		logic mul;
		logic sleep_wr;
		logic exit_wr;
		logic deliver;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] in_op;
		logic       last;
		logic       hit;
		logic       keep;
		logic       out_free;
	} dp_stat_t;

endpackage

>>> rtl/rrts_ctrl.sv
// Controller state machine of the round-robin task scheduler.
// Depends on rrts_pkg; drives the datapath rrts_dp through dp_cmd_t.
module rrts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  rrts_pkg::dp_stat_t stat,
	output rrts_pkg::dp_cmd_t  cmd
);
	import rrts_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_FIN_CUR,
		S_FIN_NEXT,
		S_CREATE,
		S_KILL,
		S_MUL,
		S_SLEEP,
		S_EXIT,
		S_DELIVER
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					case (stat.in_op)
						OP_TICK:   state_d = S_SCAN;
						OP_CREATE: state_d = S_CREATE;
						OP_KILL:   state_d = S_KILL;
						OP_SLEEP:  state_d = S_MUL;
						OP_EXIT:   state_d = S_EXIT;
						default:   state_d = S_DELIVER;
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.last) begin
					state_d = S_FIN_CUR;
				end
			end
			S_FIN_CUR: begin
				cmd.fin_cur = 1'b1;
				state_d = stat.keep ? S_DELIVER : S_FIN_NEXT;
			end
			S_FIN_NEXT: begin
				cmd.fin_next = 1'b1;
				state_d = S_DELIVER;
			end
			S_CREATE: begin
				cmd.create = 1'b1;
				if (stat.hit || stat.last) begin
					state_d = S_DELIVER;
				end
			end
			S_KILL: begin
				cmd.kill = 1'b1;
				state_d = S_DELIVER;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_SLEEP;
			end
			S_SLEEP: begin
				cmd.sleep_wr = 1'b1;
				state_d = S_DELIVER;
			end
			S_EXIT: begin
				cmd.exit_wr = 1'b1;
				state_d = S_DELIVER;
			end
			S_DELIVER: begin
				if (stat.out_free) begin
					cmd.deliver = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

>>> rtl/rrts_dp.sv
// Datapath of the round-robin task scheduler: task table, slot pointer,
// sleep-time divider and output register.
// Depends on rrts_pkg; commanded by rrts_ctrl.
module rrts_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  rrts_pkg::dp_cmd_t  cmd,
	output rrts_pkg::dp_stat_t stat,
	input  logic [2:0]         opcode,
	input  logic [3:0]         target_slot,
	input  logic [3:0]         parent_slot,
	input  logic [31:0]        sleep_ms,
	input  logic signed [31:0] exit_value,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [1:0]         status,
	output logic [3:0]         running_slot,
	output logic               switched,
	output logic [3:0]         created_slot
);
	import rrts_pkg::*;

	slot_st_t             slot_st_q [NUM_SLOTS];
	logic [SLEEP_W-1:0]   sleep_q   [NUM_SLOTS];
	logic [TICKS_W-1:0]   run_q     [NUM_SLOTS];
	logic [PARENT_W-1:0]  parent_q  [NUM_SLOTS];
	logic [CODE_W-1:0]    exit_q    [NUM_SLOTS];

	slot_ix_t            cur_q;
	slot_ix_t            ptr_q;
	slot_ix_t            cnt_q;
	slot_ix_t            next_q;
	logic                found_q;
	logic                cur_run_q;
	logic [3:0]          target_q;
	logic [PARENT_W-1:0] item_parent_q;
	logic [MS_W-1:0]     ms_q;
	logic [CODE_W-1:0]   code_q;
	logic [SLEEP_W-1:0]  quot_q;

	res_t       res_status_q;
	logic       res_switched_q;
	slot_ix_t   res_created_q;

	logic       out_valid_q;
	res_t       status_q;
	logic [3:0] running_q;
	logic       switched_q;
	logic [3:0] created_q;

	slot_ix_t           tgt_ix;
	slot_ix_t           rd_ix;
	slot_ix_t           ptr_nxt;
	slot_ix_t           cur_nxt;
	slot_st_t           rd_st;
	logic [SLEEP_W-1:0] rd_sc;
	logic [SLEEP_W-1:0] sc_dec;
	slot_st_t           wake_st;
	logic               tgt_in_range;
	logic               kill_unused;
	logic               kill_protected;
	logic [63:0]        prod;

	function automatic slot_ix_t wrap_inc(input slot_ix_t s);
		wrap_inc = (s == SLOT_LAST) ? '0 : s + 1'b1;
	endfunction

	assign tgt_ix  = SLOT_W'(target_q);
	assign rd_ix   = cmd.kill ? tgt_ix : ptr_q;
	assign ptr_nxt = wrap_inc(ptr_q);
	assign cur_nxt = wrap_inc(cur_q);
	assign rd_st   = slot_st_q[rd_ix];
	assign rd_sc   = sleep_q[rd_ix];
	assign sc_dec  = (rd_sc != '0) ? rd_sc - 1'b1 : '0;
	assign wake_st = (rd_st == ST_SLEEPING && sc_dec == '0) ? ST_READY : rd_st;

	assign tgt_in_range   = (32'(target_q) < 32'(NUM_SLOTS));
	assign kill_unused    = !tgt_in_range || rd_st == ST_UNUSED;
	assign kill_protected = (tgt_ix == IDLE_IX) || (tgt_ix == BOOT_IX);

	assign prod = 64'(ms_q) * DIV_MAGIC;

	assign stat.in_op    = opcode;
	assign stat.last     = (cnt_q == SLOT_LAST);
	assign stat.hit      = (rd_st == ST_UNUSED);
	assign stat.keep     = !found_q && cur_run_q;
	assign stat.out_free = !out_valid_q || !out_stall;

	// Task table. Each command writes at most one slot per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_st_q[i] <= (slot_ix_t'(i) == BOOT_IX) ? ST_RUNNING :
					(slot_ix_t'(i) == IDLE_IX) ? ST_READY : ST_UNUSED;
				sleep_q[i]   <= '0;
				run_q[i]     <= '0;
				parent_q[i]  <= '0;
				exit_q[i]    <= '0;
			end
		end else begin
			if (cmd.scan) begin
				if (rd_st == ST_SLEEPING) begin
					sleep_q[ptr_q]   <= sc_dec;
					slot_st_q[ptr_q] <= wake_st;
				end
				if (ptr_q == cur_q) begin
					run_q[ptr_q] <= run_q[ptr_q] + 1'b1;
				end
			end else if (cmd.fin_cur) begin
				if (!stat.keep && cur_run_q) begin
					slot_st_q[cur_q] <= ST_READY;
				end
			end else if (cmd.fin_next) begin
				slot_st_q[next_q] <= ST_RUNNING;
			end else if (cmd.create) begin
				if (rd_st == ST_UNUSED) begin
					slot_st_q[ptr_q] <= ST_READY;
					sleep_q[ptr_q]   <= '0;
					run_q[ptr_q]     <= '0;
					parent_q[ptr_q]  <= item_parent_q;
				end
			end else if (cmd.kill) begin
				if (!kill_unused && !kill_protected) begin
					slot_st_q[tgt_ix] <= ST_ZOMBIE;
					exit_q[tgt_ix]    <= KILL_CODE;
				end
			end else if (cmd.sleep_wr) begin
				slot_st_q[cur_q] <= ST_SLEEPING;
				sleep_q[cur_q]   <= quot_q;
			end else if (cmd.exit_wr) begin
				slot_st_q[cur_q] <= ST_ZOMBIE;
				exit_q[cur_q]    <= code_q;
			end
		end
	end

	// Pointer, scan bookkeeping and per-transaction result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q          <= BOOT_IX;
			ptr_q          <= '0;
			cnt_q          <= '0;
			next_q         <= '0;
			found_q        <= 1'b0;
			cur_run_q      <= 1'b0;
			res_status_q   <= RES_OK;
			res_switched_q <= 1'b0;
			res_created_q  <= '0;
		end else begin
			if (cmd.load) begin
				ptr_q          <= (opcode == OP_TICK) ? cur_nxt : '0;
				cnt_q          <= '0;
				found_q        <= 1'b0;
				cur_run_q      <= 1'b0;
				res_status_q   <= RES_OK;
				res_switched_q <= 1'b0;
				res_created_q  <= '0;
			end
			if (cmd.scan) begin
				ptr_q <= ptr_nxt;
				cnt_q <= cnt_q + 1'b1;
				if (ptr_q == cur_q) begin
					cur_run_q <= (wake_st == ST_RUNNING);
				end
				if (!found_q && wake_st == ST_READY && ptr_q != IDLE_IX) begin
					found_q <= 1'b1;
					next_q  <= ptr_q;
				end
			end
			if (cmd.fin_cur && !found_q) begin
				next_q <= IDLE_IX;
			end
			if (cmd.fin_next) begin
				cur_q          <= next_q;
				res_switched_q <= (next_q != cur_q);
			end
			if (cmd.create) begin
				ptr_q <= ptr_nxt;
				cnt_q <= cnt_q + 1'b1;
				if (rd_st == ST_UNUSED) begin
					res_created_q <= ptr_q;
				end else if (stat.last) begin
					res_status_q <= RES_FULL;
				end
			end
			if (cmd.kill) begin
				if (kill_unused) begin
					res_status_q <= RES_UNUSED;
				end else if (kill_protected) begin
					res_status_q <= RES_PROTECTED;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			target_q      <= target_slot;
			item_parent_q <= parent_slot;
			ms_q          <= sleep_ms;
			code_q        <= exit_value;
		end
		if (cmd.mul) begin
			quot_q <= prod[DIV_SHIFT +: SLEEP_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.deliver) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.deliver) begin
			status_q   <= res_status_q;
			running_q  <= 4'(cur_q);
			switched_q <= res_switched_q;
			created_q  <= 4'(res_created_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign running_slot = running_q;
	assign switched     = switched_q;
	assign created_slot = created_q;

endmodule

>>> rtl/round_robin_task_scheduler_top.sv
// Top level of the round-robin task scheduler: controller plus datapath.
// Depends on rrts_pkg, rrts_ctrl and rrts_dp.
//
//   Channel  Handshake            Fields
//   in       in_valid / in_stall  opcode, target_slot, parent_slot, sleep_ms, exit_value
//   out      out_valid/ out_stall status, running_slot, switched, created_slot
//
// One command is handled at a time; in_stall is high from acceptance until the result
// is loaded into the output register, which may still hold an earlier result.
// Tick: the scan pointer visits every table slot, one slot per cycle; then the running
// task is finished and, unless it keeps running, the next ready task is started.
// Create searches upward for the lowest free slot; sleep divides the time, then writes
// the slot; kill and exit write one slot; an unknown opcode only delivers a result.
// After reset slot 1 runs and the idle slot is ready; no clearing pass is needed.
// A stalled output delays delivery, and with it the next command, until it is taken.
module round_robin_task_scheduler_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         opcode,
	input  logic [3:0]         target_slot,
	input  logic [3:0]         parent_slot,
	input  logic [31:0]        sleep_ms,
	input  logic signed [31:0] exit_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [3:0]         running_slot,
	output logic               switched,
	output logic [3:0]         created_slot
);
	import rrts_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	rrts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	rrts_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.opcode       (opcode),
		.target_slot  (target_slot),
		.parent_slot  (parent_slot),
		.sleep_ms     (sleep_ms),
		.exit_value   (exit_value),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.status       (status),
		.running_slot (running_slot),
		.switched     (switched),
		.created_slot (created_slot)
	);

endmodule

>>> rtl/rrts_chk.sv
// Port-level checker for the round-robin task scheduler and its bind.
// Depends on rrts_pkg; attaches to round_robin_task_scheduler_top.
module rrts_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [2:0]         opcode,
	input logic [3:0]         target_slot,
	input logic [3:0]         parent_slot,
	input logic [31:0]        sleep_ms,
	input logic signed [31:0] exit_value,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         status,
	input logic [3:0]         running_slot,
	input logic               switched,
	input logic [3:0]         created_slot
);
	import rrts_pkg::*;

	// An accepted transaction blocks the input until its result is produced.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after an accepted transaction");

	// A new result only appears while a command is being processed.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a command in flight");

	// A switch is reported only with a good status and no created slot.
	a_switch_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && switched |-> status == RES_OK && created_slot == 4'd0)
		else $error("switch reported with error status or created slot");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(running_slot)
			&& $stable(switched) && $stable(created_slot))
		else $error("stalled result changed");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(opcode) && $stable(target_slot)
			&& $stable(parent_slot) && $stable(sleep_ms) && $stable(exit_value))
		else $error("stalled command changed");

endmodule

bind round_robin_task_scheduler_top rrts_chk u_rrts_chk (.*);

>>> tb/tb_round_robin_task_scheduler_top.sv
// Testbench for round_robin_task_scheduler_top: directed and random commands, checked
// against an in-bench model of the slot table. Depends on rrts_pkg and the top level.
module tb_round_robin_task_scheduler_top;
	import rrts_pkg::*;

	localparam int OP_CODE_MAX    = 7;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 40;
	localparam int CHUNKS         = 11;
	localparam int CHUNK_LEN      = 80;

	typedef struct {
		logic [2:0]  op;
		logic [3:0]  target;
		logic [3:0]  parent;
		logic [31:0] ms;
		logic [31:0] code;
	} sched_cmd_t;

	typedef struct {
		res_t       st;
		logic [3:0] running;
		logic       sw;
		logic [3:0] created;
	} sched_reply_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         opcode = '0;
	logic [3:0]         target_slot = '0;
	logic [3:0]         parent_slot = '0;
	logic [31:0]        sleep_ms = '0;
	logic signed [31:0] exit_value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic [3:0]         running_slot;
	logic               switched;
	logic [3:0]         created_slot;

	round_robin_task_scheduler_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .target_slot(target_slot), .parent_slot(parent_slot),
		.sleep_ms(sleep_ms), .exit_value(exit_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .running_slot(running_slot), .switched(switched),
		.created_slot(created_slot)
	);

	slot_st_t     task_state [NUM_SLOTS];
	logic [28:0]  sleep_left [NUM_SLOTS];
	logic [31:0]  run_count [NUM_SLOTS];
	logic [3:0]   parent_of [NUM_SLOTS];
	logic [31:0]  slot_code [NUM_SLOTS];
	slot_ix_t     cur_slot;

	sched_cmd_t   pending_cmds [$];
	sched_reply_t expected_replies [$];
	sched_cmd_t   live_cmd;
	sched_reply_t got_reply;
	logic         steady = 1'b0;
	int           gap_left = 0;
	int           stall_left = 0;
	int           idle_cycles = 0;
	int n_tick = 0, n_create = 0, n_full = 0, n_kill = 0, n_sleep = 0, n_exit = 0;
	int n_other = 0, n_switch = 0, n_checked = 0, n_mismatch = 0;

	function automatic void clear_table();
		foreach (task_state[i]) begin
			task_state[i] = ST_UNUSED;
			sleep_left[i] = '0;
			run_count[i]  = '0;
			parent_of[i]  = '0;
			slot_code[i]  = '0;
		end
		task_state[IDLE_IX] = ST_READY;
		task_state[BOOT_IX] = ST_RUNNING;
		cur_slot = BOOT_IX;
	endfunction

	function automatic logic tick_table();
		slot_ix_t cur;
		slot_ix_t nxt;
		slot_ix_t ix;
		logic     found;
		cur = cur_slot;
		nxt = cur;
		found = 1'b0;
		run_count[cur] = run_count[cur] + 32'd1;
		foreach (task_state[i]) begin
			if (task_state[i] == ST_SLEEPING) begin
				if (sleep_left[i] != '0)
					sleep_left[i] = sleep_left[i] - 29'd1;
				if (sleep_left[i] == '0)
					task_state[i] = ST_READY;
			end
		end
		for (int k = 0; k < NUM_SLOTS && !found; k++) begin
			ix = slot_ix_t'((int'(cur) + 1 + k) % NUM_SLOTS);
			if (task_state[ix] == ST_READY && ix != IDLE_IX) begin
				nxt = ix;
				found = 1'b1;
			end
		end
		if (!found) begin
			if (task_state[cur] == ST_RUNNING)
				return 1'b0;
			nxt = IDLE_IX;
		end
		if (task_state[cur] == ST_RUNNING)
			task_state[cur] = ST_READY;
		task_state[nxt] = ST_RUNNING;
		cur_slot = nxt;
		return nxt != cur;
	endfunction

	function automatic sched_reply_t exec_command(sched_cmd_t c);
		sched_reply_t r;
		logic         done;
		r.st = RES_OK;
		r.sw = 1'b0;
		r.created = '0;
		done = 1'b0;
		case (c.op)
			OP_TICK: begin
				n_tick++;
				r.sw = tick_table();
				if (r.sw)
					n_switch++;
			end
			OP_CREATE: begin
				n_create++;
				r.st = RES_FULL;
				for (int i = 0; i < NUM_SLOTS && !done; i++) begin
					if (task_state[i] == ST_UNUSED) begin
						parent_of[i]  = c.parent;
						run_count[i]  = '0;
						sleep_left[i] = '0;
						task_state[i] = ST_READY;
						r.created = 4'(i);
						r.st = RES_OK;
						done = 1'b1;
					end
				end
				if (!done)
					n_full++;
			end
			OP_KILL: begin
				n_kill++;
				if (task_state[c.target] == ST_UNUSED) begin
					r.st = RES_UNUSED;
				end else if (c.target == IDLE_IX || c.target == BOOT_IX) begin
					r.st = RES_PROTECTED;
				end else begin
					task_state[c.target] = ST_ZOMBIE;
					slot_code[c.target]  = KILL_CODE;
				end
			end
			OP_SLEEP: begin
				n_sleep++;
				sleep_left[cur_slot] = 29'(c.ms / MS_PER_TICK);
				task_state[cur_slot] = ST_SLEEPING;
			end
			OP_EXIT: begin
				n_exit++;
				task_state[cur_slot] = ST_ZOMBIE;
				slot_code[cur_slot]  = c.code;
			end
			default: begin
				n_other++;
			end
		endcase
		r.running = 4'(cur_slot);
		return r;
	endfunction

	function automatic int pick_gap(int zero_pct);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < zero_pct)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	// A negative argument leaves that field random.
	task automatic add_cmd(input logic [2:0] op, input longint target, input longint parent,
			input longint ms, input longint code);
		sched_cmd_t c;
		c.op     = op;
		c.target = (target < 0) ? 4'($urandom) : 4'(target);
		c.parent = (parent < 0) ? 4'($urandom) : 4'(parent);
		c.ms     = (ms < 0) ? $urandom : 32'(ms);
		c.code   = (code < 0) ? $urandom : 32'(code);
		pending_cmds.push_back(c);
	endtask

	task automatic add_random_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			add_cmd(OP_TICK, -1, -1, -1, -1);
		else if (r < 55)
			add_cmd(OP_CREATE, -1, -1, -1, -1);
		else if (r < 65)
			add_cmd(OP_KILL, -1, -1, -1, -1);
		else if (r < 83)
			add_cmd(OP_SLEEP, -1, -1,
					($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 60)) : -1, -1);
		else if (r < 90)
			add_cmd(OP_EXIT, -1, -1, -1, -1);
		else
			add_cmd(3'($urandom_range(OP_CODE_MAX, int'(OP_EXIT) + 1)), -1, -1, -1, -1);
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || in_valid || expected_replies.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			opcode      <= '0;
			target_slot <= '0;
			parent_slot <= '0;
			sleep_ms    <= '0;
			exit_value  <= '0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall)
				expected_replies.push_back(exec_command(live_cmd));
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					live_cmd = pending_cmds.pop_front();
					opcode      <= live_cmd.op;
					target_slot <= live_cmd.target;
					parent_slot <= live_cmd.parent;
					sleep_ms    <= live_cmd.ms;
					exit_value  <= live_cmd.code;
					in_valid    <= 1'b1;
					gap_left = pick_gap(60);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_replies.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("Result arrived with no transaction outstanding: status %0d "
								, status, "running %0d", running_slot);
				end else begin
					got_reply = expected_replies.pop_front();
					n_checked++;
					if (status !== got_reply.st || running_slot !== got_reply.running ||
							switched !== got_reply.sw || created_slot !== got_reply.created) begin
						n_mismatch++;
						if (n_mismatch <= 10)
							$display("Mismatch on result %0d (expected/actual): status %0d/%0d ",
									n_checked, got_reply.st, status,
									"running %0d/%0d switched %0b/%0b created %0d/%0d",
									got_reply.running, running_slot, got_reply.sw, switched,
									got_reply.created, created_slot);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				stall_left = pick_gap(80);
				out_stall <= (stall_left != 0);
				if (stall_left != 0)
					stall_left--;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles.", WATCHDOG_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		clear_table();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Protected and unused kills, then a short life of three created tasks: a sub-tick
		// sleep, an exit, a kill of the running task and of a zombie, and a fall back to
		// the idle task, which then sleeps and is woken by force.
		add_cmd(OP_TICK, -1, -1, -1, -1);
		add_cmd(OP_KILL, IDLE_IX, -1, -1, -1);
		add_cmd(OP_KILL, BOOT_IX, -1, -1, -1);
		add_cmd(OP_KILL, SLOT_LAST, -1, -1, -1);
		add_cmd(OP_CREATE, -1, SLOT_LAST, -1, -1);
		add_cmd(OP_CREATE, -1, 0, -1, -1);
		add_cmd(OP_CREATE, -1, -1, -1, -1);
		add_cmd(OP_TICK, -1, -1, -1, -1);
		add_cmd(OP_SLEEP, -1, -1, 9, -1);
		add_cmd(OP_TICK, -1, -1, -1, -1);
		add_cmd(OP_EXIT, -1, -1, -1, 32'h8000_0000);
		add_cmd(OP_TICK, -1, -1, -1, -1);
		add_cmd(OP_KILL, 4, -1, -1, -1);
		add_cmd(OP_KILL, 4, -1, -1, -1);
		add_cmd(OP_TICK, -1, -1, -1, -1);
		add_cmd(OP_SLEEP, -1, -1, 32'hFFFF_FFFF, -1);
		add_cmd(OP_TICK, -1, -1, -1, -1);
		add_cmd(OP_EXIT, -1, -1, -1, 32'h7FFF_FFFF);
		add_cmd(OP_TICK, -1, -1, -1, -1);
		add_cmd(OP_SLEEP, -1, -1, 25, -1);
		add_cmd(OP_TICK, -1, -1, -1, -1);
		add_cmd(OP_TICK, -1, -1, -1, -1);
		for (int op = int'(OP_EXIT) + 1; op <= OP_CODE_MAX; op++)
			add_cmd(3'(op), -1, -1, -1, -1);
		wait_drained();

		// Random chunks; every fourth one runs without idling on either side, and the
		// sender holds off until all results are back before each new chunk.
		for (int ch = 0; ch < CHUNKS; ch++) begin
			steady = (ch % 4 == 2);
			for (int n = 0; n < CHUNK_LEN; n++)
				add_random_cmd();
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d ticks (%0d switches), %0d creates (%0d on a full table), ",
				n_tick, n_switch, n_create, n_full, "%0d kills, %0d sleeps, %0d exits, ",
				n_kill, n_sleep, n_exit, "%0d unknown opcodes.", n_other);
		$display("Compared %0d results, %0d mismatches, %0d results never arrived.",
				n_checked, n_mismatch, expected_replies.size());
		if (n_mismatch == 0 && expected_replies.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> round_robin_task_scheduler_top.f
rtl/rrts_pkg.sv
rtl/rrts_ctrl.sv
rtl/rrts_dp.sv
rtl/round_robin_task_scheduler_top.sv
rtl/rrts_chk.sv
tb/tb_round_robin_task_scheduler_top.sv
